>>> rtl/core/lbp_pkg.sv
// Package for the 3x3 local binary pattern operator: sizes, register
// indexes and the position record passed from the counters to the datapath.
// No dependencies.
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int LINE_W = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd202;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd202;

  // Where the accepted item sits in the frame
  typedef struct packed {
    logic             emit;
    logic             eof;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

>>> rtl/core/lbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low. No dependencies.
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lbp_pos.sv
// Row and column counters for the pixel stream, with frame geometry clamping.
// Depends on lbp_pkg.
module lbp_pos (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      frame_start,
  input  logic [lbp_pkg::FW_W-1:0]  frame_width,
  input  logic [lbp_pkg::FH_W-1:0]  frame_height,
  output lbp_pkg::pos_t             pos
);

  logic [lbp_pkg::COL_W-1:0] column_count, column_count_next;
  logic [lbp_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [lbp_pkg::COL_W-1:0] col_eff;
  logic [lbp_pkg::ROW_W-1:0] row_eff;
  logic [lbp_pkg::FW_W-1:0]  w_eff, col_inc;
  logic [lbp_pkg::FH_W-1:0]  h_eff, row_inc;

  // Clamp geometry to the supported range
  always_comb begin
    if (frame_width < lbp_pkg::FW_W'(3)) begin
      w_eff = lbp_pkg::FW_W'(3);
    end else if (frame_width > lbp_pkg::FW_W'(lbp_pkg::MAX_WIDTH)) begin
      w_eff = lbp_pkg::FW_W'(lbp_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < lbp_pkg::FH_W'(3)) begin
      h_eff = lbp_pkg::FH_W'(3);
    end else if (frame_height > lbp_pkg::FH_W'(lbp_pkg::MAX_HEIGHT)) begin
      h_eff = lbp_pkg::FH_W'(lbp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Position of the current item and the counts after it
  always_comb begin
    col_eff = frame_start ? '0 : column_count;
    row_eff = frame_start ? '0 : row_count;
    col_inc = {1'b0, col_eff} + lbp_pkg::FW_W'(1);
    row_inc = {1'b0, row_eff} + lbp_pkg::FH_W'(1);

    pos.col  = col_eff;
    pos.emit = (row_eff >= lbp_pkg::ROW_W'(2)) && (col_eff >= lbp_pkg::COL_W'(2));
    pos.eof  = (row_inc == h_eff) && (col_inc == w_eff);

    if (col_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h_eff) ? '0 : row_inc[lbp_pkg::ROW_W-1:0];
    end else begin
      column_count_next = col_inc[lbp_pkg::COL_W-1:0];
      row_count_next    = row_eff;
    end
  end

  // Advance on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

>>> rtl/core/lbp_code.sv
// 3x3 window columns and the 8-neighbour comparison that forms the code.
// Depends on lbp_pkg.
module lbp_code (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [lbp_pkg::PIX_W-1:0] top,
  input  logic [lbp_pkg::PIX_W-1:0] mid,
  input  logic [lbp_pkg::PIX_W-1:0] px,
  output logic [lbp_pkg::PIX_W-1:0] code
);

  // w1_*: column c-1, w2_*: column c-2
  logic [lbp_pkg::PIX_W-1:0] w1_top, w1_mid, w1_bot;
  logic [lbp_pkg::PIX_W-1:0] w2_top, w2_mid, w2_bot;

  // Shift the window one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      w1_top <= '0;
      w1_mid <= '0;
      w1_bot <= '0;
      w2_top <= '0;
      w2_mid <= '0;
      w2_bot <= '0;
    end else if (shift) begin
      w2_top <= w1_top;
      w2_mid <= w1_mid;
      w2_bot <= w1_bot;
      w1_top <= top;
      w1_mid <= mid;
      w1_bot <= px;
    end
  end

  // Compare neighbours against the center, clockwise from top-left
  always_comb begin
    code[7] = w2_top > w1_mid;
    code[6] = w1_top > w1_mid;
    code[5] = top    > w1_mid;
    code[4] = mid    > w1_mid;
    code[3] = px     > w1_mid;
    code[2] = w1_bot > w1_mid;
    code[1] = w2_bot > w1_mid;
    code[0] = w2_mid > w1_mid;
  end

endmodule

>>> rtl/core/lbp_3x3_operator_top.sv
// Top level of the 3x3 local binary pattern operator: config registers, line
// store, read stage and output register. Depends on lbp_pkg, lbp_ram, lbp_pos, lbp_code.
// Path: a code reaches m_tdata through the line store read stage and then the output
// register. Throughput: one pixel per cycle unless a code is blocked at the output;
// the line store is read at accept and written back from the read stage.
// Reset: clears counts, window and valid flags, loads 202 into both geometry registers.
module lbp_3x3_operator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] pixel
  input  logic                           s_tuser,   // [0] frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] code
  output logic                           m_tlast    // end_of_frame
);

  logic [lbp_pkg::FW_W-1:0]   frame_width;
  logic [lbp_pkg::FH_W-1:0]   frame_height;
  logic                       accept;
  lbp_pkg::pos_t              pos;
  logic                       s1_valid, s1_emit, s1_eof, s1_go;
  logic [lbp_pkg::PIX_W-1:0]  s1_px;
  logic [lbp_pkg::COL_W-1:0]  s1_col;
  logic                       fwd_hit;
  logic [lbp_pkg::LINE_W-1:0] fwd_data, rdata, line_word, wdata;
  logic [lbp_pkg::PIX_W-1:0]  top, mid, code;

  // Geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lbp_pkg::FRAME_WIDTH_RESET;
      frame_height <= lbp_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[lbp_pkg::FW_W-1:0];
        lbp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: read stage moves on unless its code is blocked at the output
  assign s1_go    = s1_valid && (!s1_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;

  lbp_pos u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_start  (s_tuser),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pos          (pos)
  );

  // Line store word: high byte two rows above, low byte one row above
  assign top       = line_word[lbp_pkg::LINE_W-1:lbp_pkg::PIX_W];
  assign mid       = line_word[lbp_pkg::PIX_W-1:0];
  assign wdata     = {mid, s1_px};
  assign line_word = fwd_hit ? fwd_data : rdata;

  lbp_ram #(
    .WIDTH (lbp_pkg::LINE_W),
    .DEPTH (lbp_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata (wdata),
    .re    (accept),
    .raddr (pos.col),
    .rdata (rdata)
  );

  // Read stage: hold the item while its line word is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_go && (s1_col == pos.col);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px    <= s_tdata;
      s1_col   <= pos.col;
      s1_emit  <= pos.emit;
      s1_eof   <= pos.eof;
      fwd_data <= wdata;
    end
  end

  lbp_code u_code (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_go),
    .top   (top),
    .mid   (mid),
    .px    (s1_px),
    .code  (code)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      m_tdata <= code;
      m_tlast <= s1_eof;
    end
  end

endmodule
